>>> src/sbrq_pkg.sv
// ----------------------------------------------------------------------------
// sbrq_pkg
// Shared types, command and status codes and helper functions of the s-t
// boundary range query block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrq_pkg;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_APPEND  = 3'd1;
  localparam logic [2:0] CMD_RANGE   = 3'd2;
  localparam logic [2:0] CMD_UNBLOCK = 3'd3;
  localparam logic [2:0] CMD_POINT   = 3'd4;
  localparam logic [2:0] CMD_SLOPES  = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TIME        = 3'd1;
  localparam logic [2:0] ST_INVALID     = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam logic [2:0] DEC_STOP     = 3'd0;
  localparam logic [2:0] DEC_FOLLOW   = 3'd1;
  localparam logic [2:0] DEC_YIELD    = 3'd2;
  localparam logic [2:0] DEC_OVERTAKE = 3'd3;

  localparam logic [22:0] HORIZON_RESET = 23'd200000;
  localparam logic signed [17:0] SLOPE_DT_MS = 18'sd50;

  localparam int QUO_BITS = 26;

  typedef struct packed {
    logic [15:0]        t;
    logic signed [23:0] lo;
    logic signed [23:0] up;
  } pt_t;

  typedef struct packed {
    logic               start;
    logic signed [41:0] num;
    logic [15:0]        den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [26:0] quo;
  } div_rsp_t;

  function automatic logic signed [23:0] clamp_lo(input logic signed [23:0] x);
    clamp_lo = (x < 24'sd0) ? 24'sd0 : x;
  endfunction

  function automatic logic signed [23:0] clamp_up(input logic signed [23:0] x,
                                                  input logic [22:0] h);
    logic signed [23:0] hs;
    hs = $signed({1'b0, h});
    clamp_up = (x > hs) ? hs : x;
  endfunction

  function automatic logic signed [31:0] diff_ext(input logic signed [23:0] a,
                                                  input logic signed [23:0] b);
    logic signed [24:0] d;
    d = $signed({a[23], a}) - $signed({b[23], b});
    diff_ext = {{7{d[24]}}, d};
  endfunction

endpackage

`default_nettype wire

>>> src/sbrq_div.sv
// ----------------------------------------------------------------------------
// sbrq_div
// Iterative rounding divider: returns the numerator over the denominator,
// rounded to nearest with ties away from zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrq_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sbrq_pkg::div_req_t req_i,
  output sbrq_pkg::div_rsp_t      rsp_o
);
  import sbrq_pkg::*;

  localparam int CntW = $clog2(QUO_BITS);

  logic                busy_q;
  logic                done_q;
  logic                neg_q;
  logic [CntW-1:0]     cnt_q;
  logic [17:0]         rem_q;
  logic [16:0]         den2_q;
  logic [QUO_BITS-1:0] nrest_q;
  logic [QUO_BITS-1:0] quo_q;

  logic [41:0] mag;
  logic [43:0] nsum;
  logic [17:0] trial;
  logic        take;

  assign mag   = req_i.num[41] ? 42'(-req_i.num) : req_i.num;
  assign nsum  = {1'b0, mag, 1'b0} + {28'd0, req_i.den};
  assign trial = {rem_q[16:0], nrest_q[QUO_BITS-1]};
  assign take  = (trial >= {1'b0, den2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
      den2_q  <= '0;
      nrest_q <= '0;
      quo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        neg_q   <= req_i.num[41];
        den2_q  <= {req_i.den, 1'b0};
        rem_q   <= nsum[43:QUO_BITS];
        nrest_q <= nsum[QUO_BITS-1:0];
        quo_q   <= '0;
      end else if (busy_q) begin
        rem_q   <= take ? (trial - {1'b0, den2_q}) : trial;
        nrest_q <= {nrest_q[QUO_BITS-2:0], 1'b0};
        quo_q   <= {quo_q[QUO_BITS-2:0], take};
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QUO_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < {1'b0, den2_q}))
    else $error("Divider remainder reached the divisor.");

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("Divider started while busy.");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("Divider finished without running.");

endmodule

`default_nettype wire

>>> src/st_boundary_range_query.sv
// ----------------------------------------------------------------------------
// st_boundary_range_query
// Table of time-ordered boundary points with interpolated range, unblock,
// point-in-band and slope queries. The table sits in one synchronous memory.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  request  | in_valid_i/in_ready_o  | cmd, time_ms, lower/upper_s_in, point_s,
//           |                        | decision
//  result   | out_valid_o/out_ready_i| status, lower/upper_s_out, inside_res,
//           |                        | lower/upper_slope
//  config   | cfg_valid_i/cfg_ready_o| horizon_mm
//
// Clear and append requests, and queries on a table of fewer than two points,
// go from idle straight to the response state. A query runs a binary search
// over the memory (up to 7 steps with 64 points), two entry reads, then two
// multiplies and two 26-step divisions; slopes repeat the evaluation three
// times. A point test uses four cross-product steps in place of the
// multiplies and divisions.
// One request is worked at a time; a new one is taken while a result waits.
// Reset empties the table and sets the horizon to 200000 mm.
`default_nettype none

module st_boundary_range_query #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [15:0]        time_ms_i,
  input  wire logic signed [23:0] lower_s_in_i,
  input  wire logic signed [23:0] upper_s_in_i,
  input  wire logic signed [23:0] point_s_i,
  input  wire logic [2:0]         decision_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              status_o,
  output logic signed [23:0]      lower_s_out_o,
  output logic signed [23:0]      upper_s_out_o,
  output logic                    inside_res_o,
  output logic signed [31:0]      lower_slope_o,
  output logic signed [31:0]      upper_slope_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [22:0]        horizon_mm_i
);
  import sbrq_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_SRCH, S_SRCH_W, S_RDL, S_RDL_W, S_RDR, S_RDR_W,
    S_MUL, S_DIV_GO, S_DIV, S_CRS_A, S_CRS_B, S_FIN, S_RESP
  } state_e;

  state_e state_q;

  pt_t mem_q [MAX_POINTS];
  pt_t rd_q;

  logic [CW-1:0]      count_q;
  logic [15:0]        first_t_q, last_t_q;
  logic [22:0]        horizon_q;
  logic [2:0]         cmd_q, dec_q;
  logic [15:0]        t_q;
  logic signed [23:0] ps_q;
  logic signed [17:0] qt_q;
  logic [1:0]         ev_q;
  logic               side_q, ok_q;
  logic [CW-1:0]      lo_q, hi_q, mid_q;
  logic [AW-1:0]      l_q, r_q;
  pt_t                pl_q, pr_q;
  logic signed [41:0] prod_q;
  logic signed [42:0] p1_q;
  logic signed [23:0] iv_lo_q, iv_up_q;
  logic               su_pos_q, su_neg_q;
  logic signed [23:0] smp_lo_q [2];
  logic signed [23:0] smp_up_q [2];
  logic [1:0]         has_q;

  logic [2:0]         res_st_q;
  logic signed [23:0] res_lo_q, res_up_q;
  logic               res_in_q;
  logic signed [31:0] res_ls_q, res_us_q;

  logic               out_valid_q;
  logic [2:0]         out_st_q;
  logic signed [23:0] out_lo_q, out_up_q;
  logic               out_in_q;
  logic signed [31:0] out_ls_q, out_us_q;

  logic               accept;
  logic               app_bad, app_full, wr_en;
  logic [CW-1:0]      mid;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               in_tab, strict;
  logic signed [17:0] qt_in;
  logic signed [17:0] num;
  logic signed [24:0] ds;
  logic signed [42:0] mul_full;
  logic signed [17:0] ax, bx;
  logic signed [24:0] ay, by;
  logic signed [42:0] axby, aybx;
  logic signed [43:0] crs;
  logic signed [23:0] sel_l, sel_r;
  logic signed [23:0] c_lo, c_up;
  logic signed [31:0] dl_pn, du_pn, dl_pc, du_pc, dl_cn, du_cn;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign app_bad  = (upper_s_in_i < lower_s_in_i) ||
                    ((count_q != '0) && (time_ms_i <= last_t_q));
  assign app_full = (count_q >= CW'(MAX_POINTS));
  assign wr_en    = accept && (cmd_i == CMD_APPEND) && !app_bad && !app_full;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      S_SRCH: begin
        rd_en   = (lo_q < hi_q);
        rd_addr = mid[AW-1:0];
      end
      S_RDL: begin
        rd_en   = 1'b1;
        rd_addr = l_q;
      end
      S_RDR: begin
        rd_en   = 1'b1;
        rd_addr = r_q;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= '{t: time_ms_i, lo: lower_s_in_i, up: upper_s_in_i};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign qt_in  = $signed({2'b00, time_ms_i});
  assign in_tab = (qt_q >= $signed({2'b00, first_t_q})) &&
                  (qt_q <= $signed({2'b00, last_t_q}));
  assign strict = (qt_q > $signed({2'b00, first_t_q})) &&
                  (qt_q < $signed({2'b00, last_t_q}));

  assign num      = qt_q - $signed({2'b00, pl_q.t});
  assign ds       = side_q ? ($signed({pr_q.up[23], pr_q.up}) - $signed({pl_q.up[23], pl_q.up}))
                           : ($signed({pr_q.lo[23], pr_q.lo}) - $signed({pl_q.lo[23], pl_q.lo}));
  assign mul_full = num * ds;

  assign sel_l = side_q ? pl_q.up : pl_q.lo;
  assign sel_r = side_q ? pr_q.up : pr_q.lo;
  assign ax    = $signed({2'b00, pl_q.t}) - qt_q;
  assign bx    = $signed({2'b00, pr_q.t}) - qt_q;
  assign ay    = $signed({sel_l[23], sel_l}) - $signed({ps_q[23], ps_q});
  assign by    = $signed({sel_r[23], sel_r}) - $signed({ps_q[23], ps_q});
  assign axby  = ax * by;
  assign aybx  = ay * bx;
  assign crs   = $signed({p1_q[42], p1_q}) - $signed({aybx[42], aybx});

  assign c_lo  = clamp_lo(iv_lo_q);
  assign c_up  = clamp_up(iv_up_q, horizon_q);
  assign dl_pn = diff_ext(smp_lo_q[1], smp_lo_q[0]);
  assign du_pn = diff_ext(smp_up_q[1], smp_up_q[0]);
  assign dl_pc = diff_ext(c_lo, smp_lo_q[0]);
  assign du_pc = diff_ext(c_up, smp_up_q[0]);
  assign dl_cn = diff_ext(smp_lo_q[1], c_lo);
  assign du_cn = diff_ext(smp_up_q[1], c_up);

  assign div_req.start = (state_q == S_DIV_GO);
  assign div_req.num   = prod_q;
  assign div_req.den   = pr_q.t - pl_q.t;

  sbrq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      first_t_q   <= '0;
      last_t_q    <= '0;
      horizon_q   <= HORIZON_RESET;
      cmd_q       <= CMD_CLEAR;
      dec_q       <= DEC_STOP;
      t_q         <= '0;
      ps_q        <= '0;
      qt_q        <= '0;
      ev_q        <= '0;
      side_q      <= 1'b0;
      ok_q        <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      l_q         <= '0;
      r_q         <= '0;
      pl_q        <= '0;
      pr_q        <= '0;
      prod_q      <= '0;
      p1_q        <= '0;
      iv_lo_q     <= '0;
      iv_up_q     <= '0;
      su_pos_q    <= 1'b0;
      su_neg_q    <= 1'b0;
      smp_lo_q    <= '{default: '0};
      smp_up_q    <= '{default: '0};
      has_q       <= '0;
      res_st_q    <= ST_OK;
      res_lo_q    <= '0;
      res_up_q    <= '0;
      res_in_q    <= 1'b0;
      res_ls_q    <= '0;
      res_us_q    <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_lo_q    <= '0;
      out_up_q    <= '0;
      out_in_q    <= 1'b0;
      out_ls_q    <= '0;
      out_us_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        horizon_q <= horizon_mm_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= cmd_i;
            dec_q    <= decision_i;
            t_q      <= time_ms_i;
            ps_q     <= point_s_i;
            qt_q     <= qt_in;
            ev_q     <= 2'd2;
            res_st_q <= ST_OK;
            res_lo_q <= '0;
            res_up_q <= '0;
            res_in_q <= 1'b0;
            res_ls_q <= '0;
            res_us_q <= '0;
            state_q  <= S_RESP;
            case (cmd_i)
              CMD_CLEAR: begin
                count_q <= '0;
              end
              CMD_APPEND: begin
                if (app_bad) begin
                  res_st_q <= ST_INVALID;
                end else if (app_full) begin
                  res_st_q <= ST_FULL;
                end else begin
                  count_q  <= count_q + 1'b1;
                  last_t_q <= time_ms_i;
                  if (count_q == '0) begin
                    first_t_q <= time_ms_i;
                  end
                end
              end
              CMD_RANGE, CMD_UNBLOCK, CMD_POINT, CMD_SLOPES: begin
                if (count_q < CW'(2)) begin
                  res_st_q <= ST_TIME;
                end else if (cmd_i == CMD_SLOPES) begin
                  if ((time_ms_i < first_t_q) || (time_ms_i > last_t_q)) begin
                    res_st_q <= ST_TIME;
                  end else begin
                    ev_q    <= 2'd0;
                    qt_q    <= qt_in - SLOPE_DT_MS;
                    state_q <= S_EVAL;
                  end
                end else begin
                  state_q <= S_EVAL;
                end
              end
              default: begin
                res_st_q <= ST_OK;
              end
            endcase
          end
        end
        S_EVAL: begin
          lo_q   <= '0;
          hi_q   <= count_q;
          ok_q   <= 1'b1;
          side_q <= 1'b0;
          case (cmd_q)
            CMD_POINT: begin
              state_q <= strict ? S_SRCH : S_RESP;
            end
            CMD_UNBLOCK: begin
              res_lo_q <= '0;
              res_up_q <= $signed({1'b0, horizon_q});
              if (!in_tab) begin
                state_q <= S_RESP;
              end else if (dec_q > DEC_OVERTAKE) begin
                res_st_q <= ST_UNSUPPORTED;
                state_q  <= S_RESP;
              end else begin
                state_q <= S_SRCH;
              end
            end
            CMD_RANGE: begin
              if (!in_tab) begin
                res_st_q <= ST_TIME;
                state_q  <= S_RESP;
              end else begin
                state_q <= S_SRCH;
              end
            end
            default: begin
              ok_q    <= in_tab;
              state_q <= in_tab ? S_SRCH : S_FIN;
            end
          endcase
        end
        S_SRCH: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid;
            state_q <= S_SRCH_W;
          end else begin
            if (lo_q == '0) begin
              l_q <= '0;
              r_q <= '0;
            end else begin
              l_q <= AW'(lo_q - 1'b1);
              r_q <= lo_q[AW-1:0];
            end
            state_q <= S_RDL;
          end
        end
        S_SRCH_W: begin
          if ($signed({2'b00, rd_q.t}) < qt_q) begin
            lo_q <= mid_q + 1'b1;
          end else begin
            hi_q <= mid_q;
          end
          state_q <= S_SRCH;
        end
        S_RDL: begin
          state_q <= S_RDL_W;
        end
        S_RDL_W: begin
          pl_q <= rd_q;
          if (l_q == r_q) begin
            iv_lo_q <= rd_q.lo;
            iv_up_q <= rd_q.up;
            state_q <= S_FIN;
          end else begin
            state_q <= S_RDR;
          end
        end
        S_RDR: begin
          state_q <= S_RDR_W;
        end
        S_RDR_W: begin
          pr_q <= rd_q;
          if (cmd_q == CMD_POINT) begin
            side_q  <= 1'b1;
            state_q <= S_CRS_A;
          end else begin
            side_q  <= 1'b0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= mul_full[41:0];
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (!side_q) begin
              iv_lo_q <= pl_q.lo + div_rsp.quo[23:0];
              side_q  <= 1'b1;
              state_q <= S_MUL;
            end else begin
              iv_up_q <= pl_q.up + div_rsp.quo[23:0];
              state_q <= S_FIN;
            end
          end
        end
        S_CRS_A: begin
          p1_q    <= axby;
          state_q <= S_CRS_B;
        end
        S_CRS_B: begin
          if (side_q) begin
            su_pos_q <= (crs > 44'sd0);
            su_neg_q <= (crs < 44'sd0);
            side_q   <= 1'b0;
            state_q  <= S_CRS_A;
          end else begin
            res_in_q <= (su_pos_q && (crs < 44'sd0)) || (su_neg_q && (crs > 44'sd0));
            state_q  <= S_RESP;
          end
        end
        S_FIN: begin
          state_q <= S_RESP;
          case (cmd_q)
            CMD_RANGE: begin
              res_lo_q <= c_lo;
              res_up_q <= c_up;
            end
            CMD_UNBLOCK: begin
              if (dec_q == DEC_OVERTAKE) begin
                res_lo_q <= clamp_lo(iv_up_q);
              end else begin
                res_up_q <= iv_lo_q;
              end
            end
            CMD_SLOPES: begin
              if (ev_q == 2'd2) begin
                if (has_q[0] && has_q[1]) begin
                  res_ls_q <= (dl_pn <<< 3) + (dl_pn <<< 1);
                  res_us_q <= (du_pn <<< 3) + (du_pn <<< 1);
                end else if (has_q[0]) begin
                  res_ls_q <= (dl_pc <<< 4) + (dl_pc <<< 2);
                  res_us_q <= (du_pc <<< 4) + (du_pc <<< 2);
                end else if (has_q[1]) begin
                  res_ls_q <= (dl_cn <<< 4) + (dl_cn <<< 2);
                  res_us_q <= (du_cn <<< 4) + (du_cn <<< 2);
                end else begin
                  res_st_q <= ST_TIME;
                end
              end else begin
                smp_lo_q[ev_q[0]] <= c_lo;
                smp_up_q[ev_q[0]] <= c_up;
                has_q[ev_q[0]]    <= ok_q;
                ev_q              <= ev_q + 1'b1;
                qt_q              <= (ev_q == 2'd0) ? ($signed({2'b00, t_q}) + SLOPE_DT_MS)
                                                    : $signed({2'b00, t_q});
                state_q           <= S_EVAL;
              end
            end
            default: begin
              state_q <= S_RESP;
            end
          endcase
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_st_q    <= res_st_q;
            out_lo_q    <= res_lo_q;
            out_up_q    <= res_up_q;
            out_in_q    <= res_in_q;
            out_ls_q    <= res_ls_q;
            out_us_q    <= res_us_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign lower_s_out_o = out_lo_q;
  assign upper_s_out_o = out_up_q;
  assign inside_res_o  = out_in_q;
  assign lower_slope_o = out_ls_q;
  assign upper_slope_o = out_us_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("Point count exceeds the table size.");

  a_times_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(2)) |-> (first_t_q < last_t_q))
    else $error("First and last point times are out of order.");

  a_search_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (hi_q <= count_q))
    else $error("Search window runs past the stored points.");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("Division finished outside the wait state.");

endmodule

`default_nettype wire
